// ===== hw/rtl/pdtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtl_pkg
// shared types, codes and helpers of the pixel difference tree leaf coder
// ----------------------------------------------------------------------------
package pdtl_pkg;

    // default sizes
    localparam int DEF_TREE_DEPTH = 7;
    localparam int DEF_MAX_COLS   = 512;
    localparam int DEF_MAX_ROWS   = 512;
    localparam int DEF_NODE_COUNT = 4096;

    // field widths
    localparam int OP_W    = 2;
    localparam int PADDR_W = 18;
    localparam int PIX_W   = 8;
    localparam int NODE_W  = 12;
    localparam int OFS_W   = 16;
    localparam int THR_W   = 9;
    localparam int MAT_W   = 24;
    localparam int LM_W    = 16;
    localparam int DIM_W   = 10;
    localparam int LEAF_W  = 7;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // request ops
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
    localparam logic [OP_W-1:0] OP_NODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_WALK  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_M_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_M_XY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M_YX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LM_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LM_Y = 3'd7;

    localparam logic [DIM_W-1:0] RST_DIM = 10'd512;

    typedef struct packed {
        logic signed [OFS_W-1:0] x1;
        logic signed [OFS_W-1:0] y1;
        logic signed [OFS_W-1:0] x2;
        logic signed [OFS_W-1:0] y2;
    } node_ofs_t;

    typedef struct packed {
        logic signed [THR_W-1:0] threshold;
        logic [NODE_W-1:0]       left;
        logic [NODE_W-1:0]       right;
    } node_split_t;

    typedef struct packed {
        node_ofs_t   ofs;
        node_split_t split;
    } node_t;

    typedef struct packed {
        logic signed [MAT_W-1:0] m_xx;
        logic signed [MAT_W-1:0] m_xy;
        logic signed [MAT_W-1:0] m_yx;
        logic signed [MAT_W-1:0] m_yy;
        logic signed [LM_W-1:0]  lm_x;
        logic signed [LM_W-1:0]  lm_y;
    } mat_t;

    // node index modulo n; n >= 64 and v < 4096 so the quotient fits in six bits
    function automatic logic [NODE_W-1:0] node_wrap(input logic [NODE_W-1:0] v,
                                                    input logic [16:0] n);
        logic [22:0] r;
        logic [22:0] d;
        int          k;
        r = 23'(v);
        for (k = 5; k >= 0; k--)
        begin
            d = 23'(n) << k;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[NODE_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pixel_difference_tree_leaf_code_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_difference_tree_leaf_code_top
// image and tree node store with a pixel difference decision tree walker
// ----------------------------------------------------------------------------
// pixel and node write requests do not stall the channel; the next request can be taken the cycle after
// walk: the leaf code is registered when the compare step of the last level finishes
// a walk holds the input until it finishes; each level runs the loop of
// node read, multiply, sum/clamp, address, pixel read, compare
// reset clears control state and sets the registers to their reset values;
// the image and node stores are not cleared and hold garbage until written
module pixel_difference_tree_leaf_code_top #(
    parameter int TREE_DEPTH = pdtl_pkg::DEF_TREE_DEPTH,
    parameter int MAX_COLS   = pdtl_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = pdtl_pkg::DEF_MAX_ROWS,
    parameter int NODE_COUNT = pdtl_pkg::DEF_NODE_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [pdtl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdtl_pkg::CFG_W-1:0]         cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pdtl_pkg::OP_W-1:0]          op,
    input  logic [pdtl_pkg::PADDR_W-1:0]       pixel_address,
    input  logic [pdtl_pkg::PIX_W-1:0]         pixel_value,
    input  logic [pdtl_pkg::NODE_W-1:0]        node_address,
    input  logic signed [pdtl_pkg::OFS_W-1:0]  offset_x1,
    input  logic signed [pdtl_pkg::OFS_W-1:0]  offset_y1,
    input  logic signed [pdtl_pkg::OFS_W-1:0]  offset_x2,
    input  logic signed [pdtl_pkg::OFS_W-1:0]  offset_y2,
    input  logic signed [pdtl_pkg::THR_W-1:0]  split_threshold,
    input  logic [pdtl_pkg::NODE_W-1:0]        left_child,
    input  logic [pdtl_pkg::NODE_W-1:0]        right_child,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pdtl_pkg::LEAF_W-1:0]        leaf_code
);

    // sizes derived from the parameters
    localparam int PIX_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int NAW       = $clog2(NODE_COUNT);
    localparam int CNW       = $clog2(MAX_COLS + 1);
    localparam int RNW       = $clog2(MAX_ROWS + 1);
    localparam int CW        = $clog2(MAX_COLS);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int PW        = RW + CNW + 1;
    localparam int BW        = TREE_DEPTH - 1;
    localparam int LVL_W     = $clog2(TREE_DEPTH);
    localparam int CODE_W    = (TREE_DEPTH > 7) ? TREE_DEPTH : 7;

    // walk sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
    localparam logic [ST_W-1:0] ST_SUM  = 3'd2;
    localparam logic [ST_W-1:0] ST_ADDR = 3'd3;
    localparam logic [ST_W-1:0] ST_PIX  = 3'd4;
    localparam logic [ST_W-1:0] ST_CMP  = 3'd5;

    // configuration registers
    pdtl_pkg::mat_t     mat_reg;
    logic [pdtl_pkg::DIM_W-1:0] cols_reg;
    logic [pdtl_pkg::DIM_W-1:0] rows_reg;

    // sequencer
    logic [ST_W-1:0]    state_reg, state_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [BW-1:0]      bits_reg, bits_next;
    logic               out_valid_reg, out_valid_next;
    logic [pdtl_pkg::LEAF_W-1:0] leaf_code_reg, leaf_code_next;

    // pixel read addresses of the current level
    logic [PIX_AW-1:0]  addr_a_reg;
    logic [PIX_AW-1:0]  addr_b_reg;

    // datapath wiring
    logic               accept;
    logic               last_lvl;
    logic               go_right;
    logic               finish;
    logic [CNW-1:0]     cols_eff;
    logic [RNW-1:0]     rows_eff;
    logic [CW-1:0]      px1, px2;
    logic [RW-1:0]      py1, py2;
    logic [PIX_AW-1:0]  addr_a_next, addr_b_next;
    logic signed [9:0]  diff;
    logic [CODE_W-1:0]  code_full;
    logic [pdtl_pkg::NODE_W-1:0] child;

    // memory ports
    logic               node_we, node_re;
    logic [NAW-1:0]     node_waddr, node_raddr;
    pdtl_pkg::node_t    node_wdata, node_rdata;
    logic               pix_we, pix_re;
    logic [PIX_AW-1:0]  pix_waddr;
    logic [pdtl_pkg::PIX_W-1:0] pix_a, pix_b;

    // ------------------------------------------------------------------
    // configuration: the user, not the block, sees that it is written only while no walk is in flight
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg  <= '0;
            cols_reg <= pdtl_pkg::RST_DIM;
            rows_reg <= pdtl_pkg::RST_DIM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdtl_pkg::CFG_M_XX: mat_reg.m_xx <= cfg_data[pdtl_pkg::MAT_W-1:0];
                pdtl_pkg::CFG_M_XY: mat_reg.m_xy <= cfg_data[pdtl_pkg::MAT_W-1:0];
                pdtl_pkg::CFG_M_YX: mat_reg.m_yx <= cfg_data[pdtl_pkg::MAT_W-1:0];
                pdtl_pkg::CFG_M_YY: mat_reg.m_yy <= cfg_data[pdtl_pkg::MAT_W-1:0];
                pdtl_pkg::CFG_COLS: cols_reg     <= cfg_data[pdtl_pkg::DIM_W-1:0];
                pdtl_pkg::CFG_ROWS: rows_reg     <= cfg_data[pdtl_pkg::DIM_W-1:0];
                pdtl_pkg::CFG_LM_X: mat_reg.lm_x <= cfg_data[pdtl_pkg::LM_W-1:0];
                pdtl_pkg::CFG_LM_Y: mat_reg.lm_y <= cfg_data[pdtl_pkg::LM_W-1:0];
                default: ;
            endcase
        end
    end

    // image size limited to 1..max, zero acts as one
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = CNW'(1);
        end
        else if (13'(cols_reg) > 13'(MAX_COLS))
        begin
            cols_eff = CNW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNW'(cols_reg);
        end
        if (rows_reg == '0)
        begin
            rows_eff = RNW'(1);
        end
        else if (13'(rows_reg) > 13'(MAX_ROWS))
        begin
            rows_eff = RNW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RNW'(rows_reg);
        end
    end

    // ------------------------------------------------------------------
    // request intake: writes go straight to the stores, a walk starts
    // by reading its root node
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign node_we    = accept && (op == pdtl_pkg::OP_NODE);
    assign node_waddr = NAW'(pdtl_pkg::node_wrap(node_address, 17'(NODE_COUNT)));
    assign node_wdata = '{
        ofs:   '{x1: offset_x1, y1: offset_y1, x2: offset_x2, y2: offset_y2},
        split: '{threshold: split_threshold, left: left_child, right: right_child}
    };

    // writes beyond the image store are dropped
    assign pix_we    = accept && (op == pdtl_pkg::OP_PIXEL) &&
                       (25'(pixel_address) < 25'(PIX_DEPTH));
    assign pix_waddr = PIX_AW'(pixel_address);

    // ------------------------------------------------------------------
    // per-level datapath
    // ------------------------------------------------------------------
    pdtl_coord #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CNW      (CNW),
        .RNW      (RNW),
        .CW       (CW),
        .RW       (RW)
    ) u_coord (
        .clk  (clk),
        .ofs  (node_rdata.ofs),
        .mat  (mat_reg),
        .cols (cols_eff),
        .rows (rows_eff),
        .px1  (px1),
        .py1  (py1),
        .px2  (px2),
        .py2  (py2)
    );

    // row-major pixel address, below cols*rows by the clamp
    assign addr_a_next = PIX_AW'(PW'(py1) * PW'(cols_eff) + PW'(px1));
    assign addr_b_next = PIX_AW'(PW'(py2) * PW'(cols_eff) + PW'(px2));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADDR)
        begin
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
        end
    end

    assign pix_re = (state_reg == ST_PIX);

    pdtl_pixel_mem #(
        .PIX_DEPTH (PIX_DEPTH),
        .PIX_AW    (PIX_AW)
    ) u_pixel_mem (
        .clk     (clk),
        .we      (pix_we),
        .waddr   (pix_waddr),
        .wdata   (pixel_value),
        .re      (pix_re),
        .raddr_a (addr_a_reg),
        .raddr_b (addr_b_reg),
        .rdata_a (pix_a),
        .rdata_b (pix_b)
    );

    // split decision: below threshold goes left
    assign diff      = $signed({2'b00, pix_a}) - $signed({2'b00, pix_b});
    assign go_right  = !(diff < 10'(node_rdata.split.threshold));
    assign child     = go_right ? node_rdata.split.right : node_rdata.split.left;
    assign last_lvl  = (lvl_reg == LVL_W'(TREE_DEPTH - 2));

    // code bit of level 0 ends up as the msb after all shifts
    assign bits_next = BW'({bits_reg, go_right});
    assign code_full = CODE_W'(bits_next) + CODE_W'(1);

    // node read: root on a walk request, next child from the compare step
    assign node_re    = (accept && (op == pdtl_pkg::OP_WALK)) ||
                        ((state_reg == ST_CMP) && !last_lvl);
    assign node_raddr = (state_reg == ST_CMP) ?
                        NAW'(pdtl_pkg::node_wrap(child, 17'(NODE_COUNT))) :
                        NAW'(pdtl_pkg::node_wrap(node_address, 17'(NODE_COUNT)));

    pdtl_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .NAW        (NAW)
    ) u_node_mem (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // ------------------------------------------------------------------
    // walk sequencer and output register
    // ------------------------------------------------------------------
    // the last level waits while an earlier leaf code is still stalled
    assign finish = (state_reg == ST_CMP) && last_lvl && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && out_stall;
        leaf_code_next = leaf_code_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == pdtl_pkg::OP_WALK))
                begin
                    state_next = ST_MUL;
                    lvl_next   = '0;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_PIX;
            ST_PIX:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (!last_lvl)
                begin
                    state_next = ST_MUL;
                    lvl_next   = lvl_reg + LVL_W'(1);
                end
                else if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    leaf_code_next = code_full[pdtl_pkg::LEAF_W-1:0];
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // code bits start clean on each walk and shift in once per level before the last
    always_ff @(posedge clk)
    begin
        if (accept && (op == pdtl_pkg::OP_WALK))
        begin
            bits_reg <= '0;
        end
        else if ((state_reg == ST_CMP) && !last_lvl)
        begin
            bits_reg <= bits_next;
        end
        leaf_code_reg <= leaf_code_next;
    end

    assign out_valid = out_valid_reg;
    assign leaf_code = leaf_code_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a walk request always occupies the sequencer on the next cycle
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == pdtl_pkg::OP_WALK)) |=> in_stall)
        else $error("walk request did not start the sequencer");

    // the level counter never runs past the last level
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (lvl_reg <= LVL_W'(TREE_DEPTH - 2)))
        else $error("level counter out of range");

    // a finished walk waits rather than overwrite a stalled leaf code
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CMP) && last_lvl && out_valid_reg && out_stall)
        |=> ((state_reg == ST_CMP) && $stable(leaf_code_reg)))
        else $error("leaf code overwritten while stalled");

    // pixels are fetched only at the fetch step of a level
    a_pix_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        pix_re |-> $past(state_reg == ST_ADDR))
        else $error("pixel read without fresh addresses");

endmodule

// ===== hw/rtl/pdtl_node_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtl_node_mem
// tree node store, one write port and one registered read port
// ----------------------------------------------------------------------------
module pdtl_node_mem #(
    parameter int NODE_COUNT = pdtl_pkg::DEF_NODE_COUNT,
    parameter int NAW        = $clog2(NODE_COUNT)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [NAW-1:0]  waddr,
    input  pdtl_pkg::node_t wdata,
    input  logic            re,
    input  logic [NAW-1:0]  raddr,
    output pdtl_pkg::node_t rdata
);

    pdtl_pkg::node_t mem [NODE_COUNT];
    pdtl_pkg::node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pdtl_pixel_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtl_pixel_mem
// grayscale image store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pdtl_pixel_mem #(
    parameter int PIX_DEPTH = pdtl_pkg::DEF_MAX_COLS * pdtl_pkg::DEF_MAX_ROWS,
    parameter int PIX_AW    = $clog2(PIX_DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [PIX_AW-1:0]          waddr,
    input  logic [pdtl_pkg::PIX_W-1:0] wdata,
    input  logic                       re,
    input  logic [PIX_AW-1:0]          raddr_a,
    input  logic [PIX_AW-1:0]          raddr_b,
    output logic [pdtl_pkg::PIX_W-1:0] rdata_a,
    output logic [pdtl_pkg::PIX_W-1:0] rdata_b
);

    logic [pdtl_pkg::PIX_W-1:0] mem [PIX_DEPTH];
    logic [pdtl_pkg::PIX_W-1:0] rdata_a_reg;
    logic [pdtl_pkg::PIX_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hw/rtl/pdtl_coord.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtl_coord
// two-stage offset to pixel position mapper: products, then sum and clamp
// ----------------------------------------------------------------------------
module pdtl_coord #(
    parameter int MAX_COLS = pdtl_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = pdtl_pkg::DEF_MAX_ROWS,
    parameter int CNW      = $clog2(MAX_COLS + 1),
    parameter int RNW      = $clog2(MAX_ROWS + 1),
    parameter int CW       = $clog2(MAX_COLS),
    parameter int RW       = $clog2(MAX_ROWS)
) (
    input  logic                clk,
    input  pdtl_pkg::node_ofs_t ofs,
    input  pdtl_pkg::mat_t      mat,
    input  logic [CNW-1:0]      cols,
    input  logic [RNW-1:0]      rows,
    output logic [CW-1:0]       px1,
    output logic [RW-1:0]       py1,
    output logic [CW-1:0]       px2,
    output logic [RW-1:0]       py2
);

    localparam int PRD_W = pdtl_pkg::MAT_W + pdtl_pkg::OFS_W;

    logic signed [PRD_W-1:0] prod_reg [8];
    logic [CW-1:0] px1_reg;
    logic [RW-1:0] py1_reg;
    logic [CW-1:0] px2_reg;
    logic [RW-1:0] py2_reg;
    logic [15:0]   col_lim;
    logic [15:0]   row_lim;

    // Q12.12 times Q2.14 gives Q.26; landmark Q12.4 lines up after a shift of 22
    function automatic logic [15:0] place(input logic signed [PRD_W-1:0] pa,
                                          input logic signed [PRD_W-1:0] pb,
                                          input logic signed [pdtl_pkg::LM_W-1:0] lm,
                                          input logic [15:0] lim);
        logic signed [PRD_W+1:0] s;
        s = (PRD_W+2)'(pa) + (PRD_W+2)'(pb) + ((PRD_W+2)'(lm) <<< 22);
        if (s < 0)
        begin
            return 16'd0;
        end
        else if (s[PRD_W+1:26] > lim)
        begin
            return lim;
        end
        else
        begin
            return s[PRD_W+1:26];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= mat.m_xx * ofs.x1;
        prod_reg[1] <= mat.m_xy * ofs.y1;
        prod_reg[2] <= mat.m_yx * ofs.x1;
        prod_reg[3] <= mat.m_yy * ofs.y1;
        prod_reg[4] <= mat.m_xx * ofs.x2;
        prod_reg[5] <= mat.m_xy * ofs.y2;
        prod_reg[6] <= mat.m_yx * ofs.x2;
        prod_reg[7] <= mat.m_yy * ofs.y2;
    end

    assign col_lim = 16'(cols) - 16'd1;
    assign row_lim = 16'(rows) - 16'd1;

    always_ff @(posedge clk)
    begin
        px1_reg <= CW'(place(prod_reg[0], prod_reg[1], mat.lm_x, col_lim));
        py1_reg <= RW'(place(prod_reg[2], prod_reg[3], mat.lm_y, row_lim));
        px2_reg <= CW'(place(prod_reg[4], prod_reg[5], mat.lm_x, col_lim));
        py2_reg <= RW'(place(prod_reg[6], prod_reg[7], mat.lm_y, row_lim));
    end

    assign px1 = px1_reg;
    assign py1 = py1_reg;
    assign px2 = px2_reg;
    assign py2 = py2_reg;

endmodule

// ===== tb/pixel_difference_tree_leaf_code_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_difference_tree_leaf_code_top_tb
// self-checking bench for the pixel difference tree leaf coder: a directed
// request table with hand-worked leaf codes, then randomized phases across
// register settings, each checked against an in-bench tree walker
// ----------------------------------------------------------------------------
module pixel_difference_tree_leaf_code_top_tb;

    localparam int TREE_DEPTH = pdtl_pkg::DEF_TREE_DEPTH;
    localparam int MAX_COLS   = pdtl_pkg::DEF_MAX_COLS;
    localparam int MAX_ROWS   = pdtl_pkg::DEF_MAX_ROWS;
    localparam int NODE_COUNT = pdtl_pkg::DEF_NODE_COUNT;
    localparam int PIX_TOTAL  = MAX_COLS * MAX_ROWS;

    // field widths
    localparam int OP_W      = pdtl_pkg::OP_W;
    localparam int PADDR_W   = pdtl_pkg::PADDR_W;
    localparam int PIX_W     = pdtl_pkg::PIX_W;
    localparam int NODE_W    = pdtl_pkg::NODE_W;
    localparam int OFS_W     = pdtl_pkg::OFS_W;
    localparam int THR_W     = pdtl_pkg::THR_W;
    localparam int MAT_W     = pdtl_pkg::MAT_W;
    localparam int LM_W      = pdtl_pkg::LM_W;
    localparam int DIM_W     = pdtl_pkg::DIM_W;
    localparam int LEAF_W    = pdtl_pkg::LEAF_W;
    localparam int CFG_W     = pdtl_pkg::CFG_W;
    localparam int CFG_IDX_W = pdtl_pkg::CFG_IDX_W;

    // op code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // a walk holds the request channel until its last level is done
    localparam int WALK_CYCLES   = 5 * (TREE_DEPTH - 1) + 1;
    localparam int SETTLE_CYCLES = WALK_CYCLES + 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int END_WAIT      = 20000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 118;
    localparam int POOL_SIZE     = 32;
    localparam int NO_LEAF       = -1;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [PADDR_W-1:0]       paddr;
        logic [PIX_W-1:0]         pval;
        logic [NODE_W-1:0]        naddr;
        logic signed [OFS_W-1:0]  x1;
        logic signed [OFS_W-1:0]  y1;
        logic signed [OFS_W-1:0]  x2;
        logic signed [OFS_W-1:0]  y2;
        logic signed [THR_W-1:0]  thr;
        logic [NODE_W-1:0]        lchild;
        logic [NODE_W-1:0]        rchild;
    } tree_request_t;

    // directed row: leaf is the hand-worked code, or NO_LEAF to use the walker
    typedef struct {
        tree_request_t req;
        int            leaf;
    } directed_row_t;

    // outcome of tracing a walk through the stores as written so far
    typedef enum int { READ_OK, NODE_UNSET, PIXEL_UNSET } walk_gap_t;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [OP_W-1:0]           op;
    logic [PADDR_W-1:0]        pixel_address;
    logic [PIX_W-1:0]          pixel_value;
    logic [NODE_W-1:0]         node_address;
    logic signed [OFS_W-1:0]   offset_x1;
    logic signed [OFS_W-1:0]   offset_y1;
    logic signed [OFS_W-1:0]   offset_x2;
    logic signed [OFS_W-1:0]   offset_y2;
    logic signed [THR_W-1:0]   split_threshold;
    logic [NODE_W-1:0]         left_child;
    logic [NODE_W-1:0]         right_child;
    logic                      out_valid;
    logic                      out_stall;
    logic [LEAF_W-1:0]         leaf_code;

    // ------------------------------------------------------------------------
    // walker state: image, node stores, written flags and register copies
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0]       image_mem [0:PIX_TOTAL-1];
    bit                     image_set [0:PIX_TOTAL-1];
    pdtl_pkg::node_ofs_t    node_ofs_mem [0:NODE_COUNT-1];
    pdtl_pkg::node_split_t  node_split_mem [0:NODE_COUNT-1];
    bit                     node_set [0:NODE_COUNT-1];
    pdtl_pkg::mat_t         walk_mat;
    logic [DIM_W-1:0]       walk_cols;
    logic [DIM_W-1:0]       walk_rows;

    logic [LEAF_W-1:0] leaf_expect [$];
    logic [NODE_W-1:0] node_pool [0:POOL_SIZE-1];
    directed_row_t     directed_rows [$];

    int mismatch_count = 0;
    int requests_sent  = 0;
    int burst_left     = 0;
    int hold_seq       = 0;
    int cycle_count    = 0;

    pixel_difference_tree_leaf_code_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .pixel_address   (pixel_address),
        .pixel_value     (pixel_value),
        .node_address    (node_address),
        .offset_x1       (offset_x1),
        .offset_y1       (offset_y1),
        .offset_x2       (offset_x2),
        .offset_y2       (offset_y2),
        .split_threshold (split_threshold),
        .left_child      (left_child),
        .right_child     (right_child),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .leaf_code       (leaf_code)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit: a hung handshake ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] leaf check: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // tree walker
    // ------------------------------------------------------------------------

    // register value 0 acts as 1, anything above the store size as the size
    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Q12.12 matrix times Q2.14 offset plus Q12.4 landmark, all in Q.26;
    // negative sums land on 0, the rest truncate and clamp to the image edge
    function automatic int unsigned map_coord(input longint ma, input longint mb,
                                              input longint oa, input longint ob,
                                              input longint lm, input int unsigned size);
        longint acc;
        acc = ma * oa + mb * ob + lm * (longint'(1) << 22);
        if (acc < 0)
            return 0;
        acc = acc >>> 26;
        if (acc > longint'(size - 1))
            return size - 1;
        return int'(acc);
    endfunction

    // walks from root; stops at the first read of a never-written entry
    function automatic logic [LEAF_W-1:0] trace_walk(input logic [NODE_W-1:0] root,
                                                     output walk_gap_t gap,
                                                     output int unsigned gap_addr);
        logic [NODE_W-1:0]     cur;
        logic [31:0]           code;
        int unsigned           cols, rows, px1, py1, px2, py2, a1, a2;
        int                    lvl, diff;
        pdtl_pkg::node_ofs_t   o;
        pdtl_pkg::node_split_t s;
        cur      = root;
        code     = 1;
        gap      = READ_OK;
        gap_addr = 0;
        cols     = fit_dim(walk_cols, MAX_COLS);
        rows     = fit_dim(walk_rows, MAX_ROWS);
        for (lvl = 0; lvl < TREE_DEPTH - 1; lvl++)
        begin
            if (!node_set[cur])
            begin
                gap      = NODE_UNSET;
                gap_addr = cur;
                return '0;
            end
            o   = node_ofs_mem[cur];
            s   = node_split_mem[cur];
            px1 = map_coord($signed(walk_mat.m_xx), $signed(walk_mat.m_xy),
                            $signed(o.x1), $signed(o.y1), $signed(walk_mat.lm_x), cols);
            py1 = map_coord($signed(walk_mat.m_yx), $signed(walk_mat.m_yy),
                            $signed(o.x1), $signed(o.y1), $signed(walk_mat.lm_y), rows);
            px2 = map_coord($signed(walk_mat.m_xx), $signed(walk_mat.m_xy),
                            $signed(o.x2), $signed(o.y2), $signed(walk_mat.lm_x), cols);
            py2 = map_coord($signed(walk_mat.m_yx), $signed(walk_mat.m_yy),
                            $signed(o.x2), $signed(o.y2), $signed(walk_mat.lm_y), rows);
            a1  = py1 * cols + px1;
            a2  = py2 * cols + px2;
            if (!image_set[a1] || !image_set[a2])
            begin
                gap      = PIXEL_UNSET;
                gap_addr = image_set[a1] ? a2 : a1;
                return '0;
            end
            diff = int'(image_mem[a1]) - int'(image_mem[a2]);
            if (diff < int'($signed(s.threshold)))
                cur = s.left;
            else
            begin
                cur  = s.right;
                code = code + (32'd1 << (TREE_DEPTH - 2 - lvl));
            end
        end
        return code[LEAF_W-1:0];
    endfunction

    // update the stores for an accepted request, queue the code of a walk
    function automatic void apply_request(input tree_request_t req, input int typed_leaf);
        walk_gap_t         gap;
        int unsigned       gap_addr;
        logic [LEAF_W-1:0] code;
        case (req.op)
            pdtl_pkg::OP_PIXEL:
            begin
                if (req.paddr < PIX_TOTAL)
                begin
                    image_mem[req.paddr] = req.pval;
                    image_set[req.paddr] = 1'b1;
                end
            end
            pdtl_pkg::OP_NODE:
            begin
                node_ofs_mem[req.naddr]   = '{x1: req.x1, y1: req.y1, x2: req.x2, y2: req.y2};
                node_split_mem[req.naddr] = '{threshold: req.thr, left: req.lchild,
                                              right: req.rchild};
                node_set[req.naddr]       = 1'b1;
            end
            pdtl_pkg::OP_WALK:
            begin
                code = trace_walk(req.naddr, gap, gap_addr);
                leaf_expect.insert(leaf_expect.size(),
                                   (typed_leaf == NO_LEAF) ? code : LEAF_W'(typed_leaf));
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // holds the request until accepted, then maybe ends the burst with a gap
    task automatic send_request(input tree_request_t req, input int typed_leaf);
        in_valid        <= 1'b1;
        op              <= req.op;
        pixel_address   <= req.paddr;
        pixel_value     <= req.pval;
        node_address    <= req.naddr;
        offset_x1       <= req.x1;
        offset_y1       <= req.y1;
        offset_x2       <= req.x2;
        offset_y2       <= req.y2;
        split_threshold <= req.thr;
        left_child      <= req.lchild;
        right_child     <= req.rchild;
        do
            @(posedge clk);
        while (in_stall);
        apply_request(req, typed_leaf);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // sender goes quiet until every walk has returned its code
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (leaf_expect.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // every field random, so unused fields toggle too
    function automatic tree_request_t random_request();
        tree_request_t req;
        req.op     = OP_W'($urandom);
        req.paddr  = PADDR_W'($urandom);
        req.pval   = PIX_W'($urandom);
        req.naddr  = NODE_W'($urandom);
        req.x1     = OFS_W'($urandom);
        req.y1     = OFS_W'($urandom);
        req.x2     = OFS_W'($urandom);
        req.y2     = OFS_W'($urandom);
        req.thr    = THR_W'($urandom);
        req.lchild = NODE_W'($urandom);
        req.rchild = NODE_W'($urandom);
        return req;
    endfunction

    // child links mostly stay inside the pool so trees close up
    function automatic logic [NODE_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 88)
            return node_pool[$urandom_range(0, POOL_SIZE - 1)];
        return NODE_W'($urandom);
    endfunction

    function automatic tree_request_t node_request(input logic [NODE_W-1:0] addr);
        tree_request_t req;
        req        = random_request();
        req.op     = pdtl_pkg::OP_NODE;
        req.naddr  = addr;
        req.lchild = pick_node();
        req.rchild = pick_node();
        return req;
    endfunction

    function automatic tree_request_t pixel_request(input logic [PADDR_W-1:0] addr);
        tree_request_t req;
        req       = random_request();
        req.op    = pdtl_pkg::OP_PIXEL;
        req.paddr = addr;
        return req;
    endfunction

    // fill any node or pixel the walk would read before it is ever written,
    // then issue the walk itself
    task automatic send_walk(input logic [NODE_W-1:0] root);
        tree_request_t     req;
        walk_gap_t         gap;
        int unsigned       gap_addr;
        logic [LEAF_W-1:0] code;
        int                guard;
        guard = 0;
        forever
        begin
            code = trace_walk(root, gap, gap_addr);
            if (gap == READ_OK || guard > 400)
                break;
            if (gap == NODE_UNSET)
                send_request(node_request(NODE_W'(gap_addr)), NO_LEAF);
            else
                send_request(pixel_request(PADDR_W'(gap_addr)), NO_LEAF);
            guard++;
        end
        req       = random_request();
        req.op    = pdtl_pkg::OP_WALK;
        req.naddr = root;
        send_request(req, NO_LEAF);
    endtask

    // random value in [-lim, lim]
    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    // ------------------------------------------------------------------------
    // phase setup: registers only while the block is idle
    // ------------------------------------------------------------------------
    task automatic configure_phase(input int phase);
        pdtl_pkg::mat_t   m;
        logic [DIM_W-1:0] c;
        logic [DIM_W-1:0] r;
        int unsigned      ec, er;
        int               k;
        wait_drain();
        // pixel and node writes give no code, so let the last ones settle
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (phase)
            0:       begin c = 10'd16;   r = 10'd16;   end
            1:       begin c = 10'd1;    r = 10'd1;    end
            2:       begin c = 10'd0;    r = 10'd0;    end
            3:       begin c = 10'd1023; r = 10'd1023; end
            6:       begin c = 10'd512;  r = 10'd512;  end
            7:       begin c = DIM_W'($urandom); r = DIM_W'($urandom); end
            default: begin c = DIM_W'($urandom_range(2, 64)); r = DIM_W'($urandom_range(2, 64)); end
        endcase
        ec = fit_dim(c, MAX_COLS);
        er = fit_dim(r, MAX_ROWS);
        if (phase == 4)
        begin
            // largest positive matrix and landmark: points pile up on the edges
            m.m_xx = 24'sh7FFFFF; m.m_xy = 24'sh7FFFFF;
            m.m_yx = 24'sh7FFFFF; m.m_yy = 24'sh7FFFFF;
            m.lm_x = 16'sh7FFF;   m.lm_y = 16'sh7FFF;
        end
        else if (phase == 5)
        begin
            // most negative matrix and landmark
            m.m_xx = 24'sh800000; m.m_xy = 24'sh800000;
            m.m_yx = 24'sh800000; m.m_yy = 24'sh800000;
            m.lm_x = 16'sh8000;   m.lm_y = 16'sh8000;
        end
        else if (phase == 7)
        begin
            m.m_xx = MAT_W'($urandom); m.m_xy = MAT_W'($urandom);
            m.m_yx = MAT_W'($urandom); m.m_yy = MAT_W'($urandom);
            m.lm_x = LM_W'($urandom);  m.lm_y = LM_W'($urandom);
        end
        else
        begin
            // scale to the image so a unit offset reaches about half the width
            m.m_xx = MAT_W'(rand_span(ec * 2048));
            m.m_xy = MAT_W'(rand_span(ec * 1024));
            m.m_yx = MAT_W'(rand_span(er * 1024));
            m.m_yy = MAT_W'(rand_span(er * 2048));
            m.lm_x = LM_W'(ec * 8 + rand_span(ec * 4));
            m.lm_y = LM_W'(er * 8 + rand_span(er * 4));
        end
        // narrow registers get junk above their width, which the block drops
        write_reg(pdtl_pkg::CFG_M_XX, m.m_xx);
        write_reg(pdtl_pkg::CFG_M_XY, m.m_xy);
        write_reg(pdtl_pkg::CFG_M_YX, m.m_yx);
        write_reg(pdtl_pkg::CFG_M_YY, m.m_yy);
        write_reg(pdtl_pkg::CFG_COLS, {14'($urandom), c});
        write_reg(pdtl_pkg::CFG_ROWS, {14'($urandom), r});
        write_reg(pdtl_pkg::CFG_LM_X, {8'($urandom), m.lm_x});
        write_reg(pdtl_pkg::CFG_LM_Y, {8'($urandom), m.lm_y});
        cfg_we    <= 1'b0;
        walk_mat  = m;
        walk_cols = c;
        walk_rows = r;
        for (k = 0; k < POOL_SIZE; k++)
            node_pool[k] = NODE_W'($urandom);
    endtask

    // mostly walks over trees built from the pool, with writes and noise mixed in
    task automatic run_phase(input int phase);
        int            first, pause_at, hold_at, pick;
        int unsigned   ec, er;
        tree_request_t req;
        configure_phase(phase);
        ec       = fit_dim(walk_cols, MAX_COLS);
        er       = fit_dim(walk_rows, MAX_ROWS);
        first    = requests_sent;
        pause_at = first + $urandom_range(20, PHASE_ITEMS - 20);
        hold_at  = first + $urandom_range(10, PHASE_ITEMS - 30);
        while (requests_sent - first < PHASE_ITEMS)
        begin
            if (requests_sent >= pause_at)
            begin
                wait_drain();
                pause_at = first + PHASE_ITEMS + 1;
            end
            if (requests_sent >= hold_at)
            begin
                // receiver holds off long while requests keep coming
                hold_seq <= hold_seq + 1;
                hold_at  = first + PHASE_ITEMS + 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_request(pixel_request(PADDR_W'($urandom_range(0, er - 1) * ec +
                                                        $urandom_range(0, ec - 1))), NO_LEAF);
                else
                    send_request(pixel_request(PADDR_W'($urandom)), NO_LEAF);
            end
            else if (pick < 38)
            begin
                if ($urandom_range(0, 9) != 0)
                    send_request(node_request(node_pool[$urandom_range(0, POOL_SIZE - 1)]),
                                 NO_LEAF);
                else
                    send_request(node_request(NODE_W'($urandom)), NO_LEAF);
            end
            else if (pick < 42)
            begin
                req    = random_request();
                req.op = OP_UNUSED;
                send_request(req, NO_LEAF);
            end
            else
                send_walk(pick_node());
        end
    endtask

    // ------------------------------------------------------------------------
    // directed request table; reset leaves a zero matrix and landmark, so every
    // point of every walk reads pixel 0 and the difference is always zero
    // ------------------------------------------------------------------------
    task automatic add_row(
        input logic [OP_W-1:0] o, input logic [PADDR_W-1:0] pa, input logic [PIX_W-1:0] pv,
        input logic [NODE_W-1:0] na, input logic [OFS_W-1:0] x1, input logic [OFS_W-1:0] y1,
        input logic [OFS_W-1:0] x2, input logic [OFS_W-1:0] y2, input logic [THR_W-1:0] th,
        input logic [NODE_W-1:0] lc, input logic [NODE_W-1:0] rc, input int leaf);
        directed_row_t row;
        row.req = '{op: o, paddr: pa, pval: pv, naddr: na, x1: x1, y1: y1, x2: x2, y2: y2,
                    thr: th, lchild: lc, rchild: rc};
        row.leaf = leaf;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic build_directed_rows();
        // pixel writes at both address ends, unused fields at their extremes
        add_row(pdtl_pkg::OP_PIXEL, 18'h00000, 8'hFF, 12'hFFF,
            16'h8000, 16'h8000, 16'h8000, 16'h8000, 9'h100, 12'hFFF, 12'hFFF, NO_LEAF);
        add_row(pdtl_pkg::OP_PIXEL, 18'h3FFFF, 8'h00, 12'h000,
            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 9'h0FF, 12'h000, 12'h000, NO_LEAF);
        add_row(pdtl_pkg::OP_PIXEL, 18'h2AAAA, 8'h55, 12'h555,
            16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 9'h155, 12'h555, 12'hAAA, NO_LEAF);
        add_row(pdtl_pkg::OP_PIXEL, 18'h15555, 8'hAA, 12'hAAA,
            16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 9'h0AA, 12'hAAA, 12'h555, NO_LEAF);
        // node 4095: threshold 0 always goes right, back to itself
        add_row(pdtl_pkg::OP_NODE, 18'h3FFFF, 8'hFF, 12'hFFF,
            16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 9'h000, 12'h000, 12'hFFF, NO_LEAF);
        // node 0: lowest threshold goes right to 4095
        add_row(pdtl_pkg::OP_NODE, 18'h00000, 8'h00, 12'h000,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'h100, 12'h001, 12'hFFF, NO_LEAF);
        // node 1: highest threshold always goes left, back to itself
        add_row(pdtl_pkg::OP_NODE, 18'h2AAAA, 8'h55, 12'h001,
            16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 9'h0FF, 12'h001, 12'h000, NO_LEAF);
        // node 2: threshold 1 sits just above a zero difference, left to 4095
        add_row(pdtl_pkg::OP_NODE, 18'h15555, 8'hAA, 12'h002,
            16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 9'h001, 12'hFFF, 12'h001, NO_LEAF);
        // node 3: threshold 0 meets a zero difference, right to node 1
        add_row(pdtl_pkg::OP_NODE, 18'h00000, 8'h00, 12'h003,
            16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 9'h000, 12'h002, 12'h001, NO_LEAF);
        // all right: top leaf
        add_row(pdtl_pkg::OP_WALK, 18'h3FFFF, 8'hFF, 12'h000,
            16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 9'h1FF, 12'hFFF, 12'h000, 64);
        // all left: first leaf
        add_row(pdtl_pkg::OP_WALK, 18'h00000, 8'h00, 12'h001,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'h000, 12'h000, 12'hFFF, 1);
        // left once, then right five times
        add_row(pdtl_pkg::OP_WALK, 18'h2AAAA, 8'h55, 12'h002,
            16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 9'h155, 12'h555, 12'h555, 32);
        // right once, then left five times
        add_row(pdtl_pkg::OP_WALK, 18'h15555, 8'hAA, 12'h003,
            16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 9'h0AA, 12'hAAA, 12'hAAA, 33);
        // unused op with everything set, then everything clear: no code must come back
        add_row(OP_UNUSED, 18'h3FFFF, 8'hFF, 12'hFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF, 12'hFFF, 12'hFFF, NO_LEAF);
        add_row(OP_UNUSED, 18'h00000, 8'h00, 12'h000,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'h000, 12'h000, 12'h000, NO_LEAF);
        // rewrite pixel 0: both points still read it
        add_row(pdtl_pkg::OP_PIXEL, 18'h00000, 8'h00, 12'h123,
            16'h1234, 16'h4321, 16'h7FFF, 16'h8000, 9'h0FF, 12'hFFF, 12'h000, NO_LEAF);
        add_row(pdtl_pkg::OP_WALK, 18'h00000, 8'h00, 12'hFFF,
            16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 9'h100, 12'h000, 12'hFFF, 64);
        add_row(pdtl_pkg::OP_WALK, 18'h3FFFF, 8'hFF, 12'h002,
            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 9'h0FF, 12'hFFF, 12'hFFF, NO_LEAF);
        add_row(pdtl_pkg::OP_WALK, 18'h3FFFF, 8'hFF, 12'h000,
            16'h8000, 16'h8000, 16'h8000, 16'h8000, 9'h100, 12'h000, 12'h000, NO_LEAF);
    endtask

    // ------------------------------------------------------------------------
    // result side: stall pattern of its own, with long hold-offs on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int hold_seen;
        int seg_left;
        int mode;
        hold_seen = 0;
        seg_left  = 0;
        mode      = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // every accepted code against the oldest walk still outstanding
    always @(posedge clk)
    begin : leaf_check
        logic [LEAF_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (leaf_expect.size() == 0)
                report_mismatch($sformatf("code %0d with no walk outstanding", leaf_code));
            else
            begin
                want = leaf_expect.pop_front();
                if (leaf_code !== want)
                    report_mismatch($sformatf("leaf_code %0d, want %0d", leaf_code, want));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int k;
        int waited;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        op              <= '0;
        pixel_address   <= '0;
        pixel_value     <= '0;
        node_address    <= '0;
        offset_x1       <= '0;
        offset_y1       <= '0;
        offset_x2       <= '0;
        offset_y2       <= '0;
        split_threshold <= '0;
        left_child      <= '0;
        right_child     <= '0;
        // walker starts from the register reset values
        walk_mat  = '0;
        walk_cols = pdtl_pkg::RST_DIM;
        walk_rows = pdtl_pkg::RST_DIM;
        for (k = 0; k < NODE_COUNT; k++)
            node_set[k] = 1'b0;
        for (k = 0; k < PIX_TOTAL; k++)
            image_set[k] = 1'b0;
        for (k = 0; k < POOL_SIZE; k++)
            node_pool[k] = NODE_W'($urandom);
        build_directed_rows();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part runs on the reset register values
        burst_left = $urandom_range(1, 8);
        for (k = 0; k < directed_rows.size(); k++)
            send_request(directed_rows[k].req, directed_rows[k].leaf);

        // randomized phases, each on a fresh register setting
        for (k = 0; k < NUM_PHASES; k++)
            run_phase(k);

        // drain with a bound, then let the pipe go quiet
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (leaf_expect.size() != 0 && waited < END_WAIT);
        if (leaf_expect.size() != 0)
            report_mismatch($sformatf("%0d leaf codes never came back", leaf_expect.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
